>>> design/jclp_pkg.sv
package jclp_pkg;

  localparam int unsigned Connections = 4;
  localparam int unsigned LineWrap    = 32;
  localparam int unsigned ConnW       = 2;
  localparam int unsigned CountW      = $clog2(LineWrap);

  localparam logic [7:0] CharNul     = 8'd0;
  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharSpace   = 8'd32;
  localparam logic [7:0] CharPlus    = 8'd43;
  localparam logic [7:0] CharMinus   = 8'd45;
  localparam logic [7:0] CharZero    = 8'd48;
  localparam logic [7:0] CharNine    = 8'd57;
  localparam logic [7:0] CharTab     = 8'd9;
  localparam logic [7:0] CharCr      = 8'd13;

  localparam logic [31:0] DevJ1 = 32'd74 << 1;
  localparam logic [31:0] DevJ2 = 32'd74 << 2;
  localparam logic [31:0] DevK1 = 32'd75 << 1;
  localparam logic [31:0] DevM1 = 32'd77 << 1;
  localparam logic [31:0] DevP1 = 32'd80 << 1;
  localparam logic [31:0] DevP2 = 32'd80 << 2;

  localparam logic [3:0] DevShiftMask = 4'hF;
  localparam logic [31:0] KeyMask     = 32'h7F;

  typedef enum logic [2:0] {
    ActNone    = 3'd0,
    ActStick0  = 3'd1,
    ActStick1  = 3'd2,
    ActKey     = 3'd3,
    ActPaddleX = 3'd4,
    ActPaddleY = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    PhLead   = 2'd0,
    PhSign   = 2'd1,
    PhDigits = 2'd2,
    PhDone   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    TokId   = 3'd0,
    TokX    = 3'd1,
    TokY    = 3'd2,
    TokBtn  = 3'd3,
    TokRest = 3'd4
  } token_e;

  typedef struct packed {
    logic [CountW-1:0] byte_count;
    token_e            token_number;
    logic              inside_token;
    logic              line_cut;
    logic [7:0]        id_first_char;
    logic [7:0]        id_second_char;
    logic [1:0]        id_length;
    phase_e            number_phase;
    logic              number_negative;
    logic [31:0]       number_accum;
    logic [31:0]       saved_x;
    logic [31:0]       saved_y;
    logic [1:0]        saved_buttons;
  } line_t;

  typedef struct packed {
    action_e            action;
    logic signed [23:0] first_axis;
    logic signed [23:0] second_axis;
    logic [1:0]         button_bits;
    logic [6:0]         key_code;
  } result_t;

endpackage

>>> design/jclp_action_decode.sv
module jclp_action_decode import jclp_pkg::*; (
  input  line_t   line_i,
  output result_t result_o
);

  logic [31:0] first_ext;
  logic [31:0] dev;

  always_comb begin
    first_ext = {{24{line_i.id_first_char[7]}}, line_i.id_first_char};
    if (line_i.id_length == 2'd2) begin
      dev = first_ext << (line_i.id_second_char[3:0] & DevShiftMask);
    end else begin
      dev = '0;
    end
  end

  always_comb begin
    result_o = '0;
    if (dev == DevJ1 || dev == DevJ2) begin
      result_o.action      = (dev == DevJ1) ? ActStick0 : ActStick1;
      result_o.first_axis  = line_i.saved_x[31:8];
      result_o.second_axis = line_i.saved_y[31:8];
      result_o.button_bits = line_i.saved_buttons;
    end else if (dev == DevK1) begin
      result_o.action   = ActKey;
      result_o.key_code = 7'(line_i.saved_x & KeyMask);
    end else if (dev == DevP1 || dev == DevP2) begin
      result_o.action      = (dev == DevP1) ? ActPaddleX : ActPaddleY;
      result_o.first_axis  = line_i.saved_x[31:8];
      result_o.button_bits = line_i.saved_buttons;
    end else if (dev == DevM1) begin
      result_o.action = ActNone;
    end
  end

endmodule

>>> design/jclp_line_step.sv
module jclp_line_step import jclp_pkg::*; (
  input  logic       func_i,
  input  logic [7:0] data_byte_i,
  input  line_t      line_i,
  output line_t      line_o,
  output logic       res_valid_o,
  output result_t    result_o
);

  line_t committed;

  function automatic line_t commit(line_t s);
    logic [31:0] v;
    line_t       r;
    r = s;
    v = s.number_negative ? (32'd0 - s.number_accum) : s.number_accum;
    case (s.token_number)
      TokX:    r.saved_x = v;
      TokY:    r.saved_y = v;
      TokBtn:  r.saved_buttons = v[1:0];
      default: ;
    endcase
    if (s.token_number != TokRest) begin
      r.token_number = token_e'(s.token_number + 3'd1);
    end
    r.inside_token = 1'b0;
    return r;
  endfunction

  function automatic line_t token_byte(line_t s, logic [7:0] b);
    line_t       r;
    logic        digit;
    logic [31:0] dval;
    r     = s;
    digit = b inside {[CharZero:CharNine]};
    dval  = {24'd0, b - CharZero};
    if (!s.inside_token) begin
      r.inside_token    = 1'b1;
      r.number_phase    = PhLead;
      r.number_negative = 1'b0;
      r.number_accum    = '0;
    end
    if (s.token_number == TokId) begin
      if (s.id_length == 2'd0) begin
        r.id_first_char = b;
      end else if (s.id_length == 2'd1) begin
        r.id_second_char = b;
      end
      if (s.id_length != 2'd3) begin
        r.id_length = s.id_length + 2'd1;
      end
    end else if (s.token_number != TokRest) begin
      case (r.number_phase)
        PhLead: begin
          if (b inside {[CharTab:CharCr]}) begin
            r.number_phase = PhLead;
          end else if (b == CharPlus || b == CharMinus) begin
            r.number_negative = (b == CharMinus);
            r.number_phase    = PhSign;
          end else if (digit) begin
            r.number_accum = dval;
            r.number_phase = PhDigits;
          end else begin
            r.number_phase = PhDone;
          end
        end
        PhSign, PhDigits: begin
          if (digit) begin
            r.number_accum = (r.number_accum << 3) + (r.number_accum << 1) + dval;
            r.number_phase = PhDigits;
          end else begin
            r.number_phase = PhDone;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  always_comb begin
    line_o      = line_i;
    committed   = line_i;
    res_valid_o = 1'b0;
    if (func_i) begin
      line_o = '0;
    end else if (data_byte_i == CharNewline) begin
      committed   = line_i.inside_token ? commit(line_i) : line_i;
      res_valid_o = 1'b1;
      line_o      = '0;
    end else begin
      if (!line_i.line_cut) begin
        if (data_byte_i == CharNul) begin
          line_o          = line_i.inside_token ? commit(line_i) : line_i;
          line_o.line_cut = 1'b1;
        end else if (data_byte_i == CharSpace) begin
          line_o = line_i.inside_token ? commit(line_i) : line_i;
        end else begin
          line_o = token_byte(line_i, data_byte_i);
        end
      end
      if (line_i.byte_count == CountW'(LineWrap - 1)) begin
        line_o = '0;
      end else begin
        line_o.byte_count = line_i.byte_count + CountW'(1);
      end
    end
  end

  jclp_action_decode u_decode (
    .line_i   (committed),
    .result_o (result_o)
  );

endmodule

>>> design/joystick_command_line_parser.sv
// Joystick command line parser.
// Input channel (in_valid_i/in_ready_o) carries one request per byte: func_i
// selects a data byte or a clear of the connection's line, connection_i picks
// one of four connections and data_byte_i holds the character. Each
// connection keeps its own partial line; a newline produces one result on
// the output channel (out_valid_o/out_ready_i) with the action code, the two
// axes shifted right by eight, the button bits and the key code. Other bytes
// and clears produce nothing.
// An accepted request is held in the input register; its result is held in
// the result register. One request per cycle is taken sustained while the
// receiver does not stall: per-connection state lives in flip-flops and is
// updated by a single pass of logic between the input and result registers,
// so a request to the same connection in the next cycle sees the update.
// Reset clears every connection's line state and empties both registers.
// When the receiver stalls with a result pending, the processing stage
// holds, and in_ready_o drops once the input register is also full.
module joystick_command_line_parser import jclp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [ConnW-1:0]    connection_i,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          action_o,
  output logic signed [23:0]  first_axis_o,
  output logic signed [23:0]  second_axis_o,
  output logic [1:0]          button_bits_o,
  output logic [6:0]          key_code_o
);

  logic             in_valid_q, in_valid_d;
  logic             func_q;
  logic [ConnW-1:0] conn_q;
  logic [7:0]       byte_q;
  logic             out_valid_q, out_valid_d;
  result_t          res_q;
  line_t            state_q [Connections];

  logic    stage_go;
  logic    conn_ok;
  line_t   next_line;
  logic    res_valid;
  result_t result;

  assign stage_go   = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || stage_go;
  assign conn_ok    = 32'(conn_q) < Connections;

  assign in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
  assign out_valid_d = stage_go ? (in_valid_q && conn_ok && res_valid) : out_valid_q;

  jclp_line_step u_step (
    .func_i      (func_q),
    .data_byte_i (byte_q),
    .line_i      (state_q[conn_q]),
    .line_o      (next_line),
    .res_valid_o (res_valid),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{default: '0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (stage_go && in_valid_q && conn_ok) begin
        state_q[conn_q] <= next_line;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      conn_q <= connection_i;
      byte_q <= data_byte_i;
    end
    if (stage_go && in_valid_q) begin
      res_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = res_q.action;
  assign first_axis_o  = res_q.first_axis;
  assign second_axis_o = res_q.second_axis;
  assign button_bits_o = res_q.button_bits;
  assign key_code_o    = res_q.key_code;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while both stages are blocked");

  a_newline_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_go && in_valid_q && conn_ok && !func_q && byte_q == CharNewline
    |=> out_valid_q)
    else $error("newline did not produce a result");

  a_key_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ActKey
    |-> first_axis_o == 24'sd0 && second_axis_o == 24'sd0 && button_bits_o == 2'd0)
    else $error("key result carries axis or button data");

  a_second_axis_stick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != ActStick0 && action_o != ActStick1
    |-> second_axis_o == 24'sd0)
    else $error("second axis set on a non-stick result");
`endif

endmodule
